>>> hw/rtl/fcvs_pkg.sv
// shared types, constants and the carrier table for the fm carrier volume shadow
package fcvs_pkg;

    typedef enum logic [1:0] {
        ACT_WRITE  = 2'd0,
        ACT_VOLUME = 2'd1,
        ACT_MUTE   = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FWD,
        S_OPS
    } state_t;

    localparam logic [8:0]        MODE_REG    = 9'h027;
    localparam logic [6:0]        LEVEL_MAX   = 7'h7f;
    localparam logic [3:0]        LEVEL_HI    = 4'h4;
    localparam logic [5:0]        ALG_HI      = 6'h2c;
    localparam logic signed [7:0] MUTE_VOLUME = -8'sd127;
    localparam logic signed [7:0] OPEN_VOLUME = 8'sd0;

    // one result beat from the sequencer to the output register
    typedef struct packed {
        logic       valid;
        logic [8:0] addr;
        logic [7:0] data;
        logic       last;
    } res_t;

    // carrier operator mask per algorithm
    function automatic logic [3:0] carrier_mask(input logic [2:0] alg);
        logic [3:0] m;
        case (alg)
            3'd4:    m = 4'hc;
            3'd5:    m = 4'he;
            3'd6:    m = 4'he;
            3'd7:    m = 4'hf;
            default: m = 4'h8;
        endcase
        return m;
    endfunction

endpackage

>>> hw/rtl/fcvs_level_unit.sv
// shared subtract and saturate unit: level minus volume clamped to 0..127
module fcvs_level_unit
    import fcvs_pkg::*;
(
    input  logic [6:0]        level,
    input  logic signed [7:0] vol,
    output logic [7:0]        data
);

    logic signed [9:0] diff;

    assign diff = $signed({3'b000, level}) - 10'(vol);

    always_comb
    begin
        if (diff < 10'sd0)
        begin
            data = 8'd0;
        end
        else if (diff > $signed({3'b000, LEVEL_MAX}))
        begin
            data = {1'b0, LEVEL_MAX};
        end
        else
        begin
            data = {1'b0, diff[6:0]};
        end
    end

endmodule

>>> hw/rtl/fcvs_sequencer.sv
// shadow registers and the sequencer that walks channels and operator slots
module fcvs_sequencer
    import fcvs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_accept,
    input  logic [1:0]        action,
    input  logic [8:0]        reg_addr,
    input  logic [7:0]        reg_data,
    input  logic [2:0]        channel,
    input  logic signed [7:0] volume,
    input  logic              mute_on,
    input  logic              has_extend,
    input  logic              take,
    output logic              busy,
    output res_t              res
);

    state_t            state_reg, state_next;
    logic [2:0]        ch_reg, ch_next;
    logic [1:0]        slot_reg, slot_next;
    logic signed [7:0] vol_reg, vol_next;
    logic              mute_reg, mute_next;
    logic [8:0]        fwd_addr_reg, fwd_addr_next;
    logic [7:0]        fwd_data_reg, fwd_data_next;
    logic [1:0]        mode_reg, mode_next;
    logic [6:0]        level_reg [32];
    logic [2:0]        alg_reg [8];

    logic              lvl_we, alg_we;
    logic [4:0]        lvl_widx, lvl_ridx;
    logic [2:0]        alg_widx;
    logic [3:0]        mask;
    logic              slot_on, chan_last, advance;
    logic [2:0]        ch_after;
    logic [7:0]        unit_data;

    assign busy     = (state_reg != S_IDLE);
    assign lvl_ridx = {ch_reg[2], slot_reg, ch_reg[1:0]};
    assign mask     = carrier_mask(alg_reg[ch_reg]);
    assign slot_on  = mask[slot_reg];

    fcvs_level_unit u_level (
        .level (level_reg[lvl_ridx]),
        .vol   (vol_reg),
        .data  (unit_data)
    );

    // mute order is 0 4 1 5 2 6 with the second bank, else 0 1 2
    always_comb
    begin
        if (!mute_reg)
        begin
            chan_last = 1'b1;
        end
        else if (has_extend)
        begin
            chan_last = (ch_reg == 3'd6);
        end
        else
        begin
            chan_last = (ch_reg == 3'd2);
        end
        if (has_extend)
        begin
            ch_after = ch_reg[2] ? {1'b0, ch_reg[1:0] + 2'd1} : {1'b1, ch_reg[1:0]};
        end
        else
        begin
            ch_after = ch_reg + 3'd1;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        ch_next       = ch_reg;
        slot_next     = slot_reg;
        vol_next      = vol_reg;
        mute_next     = mute_reg;
        fwd_addr_next = fwd_addr_reg;
        fwd_data_next = fwd_data_reg;
        mode_next     = mode_reg;
        lvl_we        = 1'b0;
        alg_we        = 1'b0;
        lvl_widx      = {reg_addr[8], reg_addr[3:0]};
        alg_widx      = {reg_addr[8], reg_addr[1:0]};
        res           = '0;
        advance       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    fwd_addr_next = reg_addr;
                    fwd_data_next = reg_data;
                    slot_next     = 2'd0;
                    case (action_t'(action))
                        ACT_WRITE:
                        begin
                            // psg range gives nothing
                            if (reg_addr[8:4] != 5'd0)
                            begin
                                if (reg_addr == MODE_REG)
                                begin
                                    fwd_data_next = {reg_data[7:6], 6'd0};
                                    if (reg_data[7:6] != mode_reg)
                                    begin
                                        mode_next  = reg_data[7:6];
                                        state_next = S_FWD;
                                    end
                                end
                                else
                                begin
                                    lvl_we     = (reg_addr[7:4] == LEVEL_HI);
                                    alg_we     = (reg_addr[7:2] == ALG_HI);
                                    state_next = S_FWD;
                                end
                            end
                        end
                        ACT_VOLUME:
                        begin
                            ch_next    = channel;
                            vol_next   = volume;
                            mute_next  = 1'b0;
                            state_next = S_OPS;
                        end
                        ACT_MUTE:
                        begin
                            ch_next    = 3'd0;
                            vol_next   = mute_on ? MUTE_VOLUME : OPEN_VOLUME;
                            mute_next  = 1'b1;
                            state_next = S_OPS;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_FWD:
            begin
                res.valid = 1'b1;
                res.addr  = fwd_addr_reg;
                res.data  = fwd_data_reg;
                res.last  = 1'b1;
                if (take)
                begin
                    state_next = S_IDLE;
                end
            end
            S_OPS:
            begin
                res.valid = slot_on;
                res.addr  = {ch_reg[2], LEVEL_HI, slot_reg, ch_reg[1:0]};
                res.data  = unit_data;
                // every algorithm has a carrier in the top slot
                res.last  = (slot_reg == 2'd3) && chan_last;
                advance   = !slot_on || take;
                if (advance)
                begin
                    slot_next = slot_reg + 2'd1;
                    if (slot_reg == 2'd3)
                    begin
                        if (chan_last)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            ch_next = ch_after;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg  <= 2'd0;
            for (int i = 0; i < 32; i++)
            begin
                level_reg[i] <= LEVEL_MAX;
            end
            for (int i = 0; i < 8; i++)
            begin
                alg_reg[i] <= 3'd0;
            end
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            if (lvl_we)
            begin
                level_reg[lvl_widx] <= reg_data[6:0];
            end
            if (alg_we)
            begin
                alg_reg[alg_widx] <= reg_data[2:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg       <= ch_next;
        slot_reg     <= slot_next;
        vol_reg      <= vol_next;
        mute_reg     <= mute_next;
        fwd_addr_reg <= fwd_addr_next;
        fwd_data_reg <= fwd_data_next;
    end

    // the top slot always carries a beat
    a_top_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OPS && slot_reg == 2'd3) |-> res.valid)
        else $error("top operator slot produced no beat");

    // a taken final beat ends the item
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (take && res.valid && res.last) |=> (state_reg == S_IDLE))
        else $error("sequencer kept running after final beat");

    // ops beats only target total level registers of the current channel
    a_ops_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OPS && res.valid) |->
        (res.addr[7:4] == LEVEL_HI && res.addr[1:0] == ch_reg[1:0] && res.addr[8] == ch_reg[2]))
        else $error("ops beat with wrong address");

    // shadows change only on an accepted write
    a_shadow_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (lvl_we || alg_we) |-> (in_accept && state_reg == S_IDLE))
        else $error("shadow written outside an accepted write");

endmodule

>>> hw/rtl/fm_carrier_volume_shadow.sv
// top level: fm register bus front end with total level shadowing and volume writes
//
// input channel: in_valid/in_stall with action, reg_addr, reg_data, channel, volume,
// mute_on. an input beat is taken when in_valid is high and in_stall low.
// output channel: out_valid/out_stall with out_addr, out_data, last; last marks the
// final synthesizer write caused by one input beat.
// has_extend is written through has_extend_we/has_extend_data; the user must
// write it only while idle, the block does not enforce this. a register write
// gives at most one output beat. a volume action walks the four operator
// slots of the channel, one slot per cycle while the output is not stalled,
// through the shared subtract and saturate unit, and gives one to four beats;
// a mute action does the same for channels 0 1 2, and 4 5 6 with the second
// bank. in_stall is high while the sequencer works on an item; the next item
// is taken the cycle after the last beat has moved into the output register,
// and a beat with no result does not raise in_stall. a stalled output beat
// holds the sequencer on its slot until the beat moves on. reset clears all
// level shadows to 0x7f, algorithms and mode bits to zero and sets has_extend;
// no beat is pending after reset.
module fm_carrier_volume_shadow
    import fcvs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        action,
    input  logic [8:0]        reg_addr,
    input  logic [7:0]        reg_data,
    input  logic [2:0]        channel,
    input  logic signed [7:0] volume,
    input  logic              mute_on,
    input  logic              has_extend_we,
    input  logic              has_extend_data,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [8:0]        out_addr,
    output logic [7:0]        out_data,
    output logic              last
);

    logic       has_extend_reg;
    logic       busy;
    logic       take;
    res_t       res;
    logic       out_valid_reg, out_valid_next;
    logic [8:0] out_addr_reg;
    logic [7:0] out_data_reg;
    logic       last_reg;

    assign in_stall = busy;

    fcvs_sequencer u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_accept  (in_valid && !busy),
        .action     (action),
        .reg_addr   (reg_addr),
        .reg_data   (reg_data),
        .channel    (channel),
        .volume     (volume),
        .mute_on    (mute_on),
        .has_extend (has_extend_reg),
        .take       (take),
        .busy       (busy),
        .res        (res)
    );

    // output register takes a beat when empty or draining
    assign take = res.valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            has_extend_reg <= 1'b1;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (has_extend_we)
            begin
                has_extend_reg <= has_extend_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_addr_reg <= res.addr;
            out_data_reg <= res.data;
            last_reg     <= res.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_addr  = out_addr_reg;
    assign out_data  = out_data_reg;
    assign last      = last_reg;

endmodule

>>> test/fm_carrier_volume_shadow_chk.sv
// checker: predicts the synthesizer writes of each accepted beat and compares them on the output
module fm_carrier_volume_shadow_chk
    import fcvs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [1:0]        action,
    input  logic [8:0]        reg_addr,
    input  logic [7:0]        reg_data,
    input  logic [2:0]        channel,
    input  logic signed [7:0] volume,
    input  logic              mute_on,
    input  logic              has_extend_we,
    input  logic              has_extend_data,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [8:0]        out_addr,
    input  logic [7:0]        out_data,
    input  logic              last,
    output int                errors,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [8:0]  PSG_TOP   = 9'h010;
    localparam logic [7:0]  MODE_MASK = 8'hc0;
    // carrier operator masks, one nibble per algorithm, algorithm 0 in the low nibble
    localparam logic [31:0] CARRIER_TABLE = 32'hfeec_8888;

    typedef struct packed {
        logic [8:0] addr;
        logic [7:0] data;
        logic       last;
    } fm_write_t;

    logic [6:0] level_copy [32];
    logic [2:0] alg_copy [8];
    logic [1:0] mode_copy;
    logic       extend_copy;
    fm_write_t  synth_writes_q [$];
    fm_write_t  want;

    // one write per carrier slot of the channel, level minus volume clamped to 0..127
    task automatic queue_channel(input logic [2:0] ch, input int vol);
        logic [3:0] mask;
        logic [4:0] idx;
        int lv;
        mask = CARRIER_TABLE[alg_copy[ch] * 4 +: 4];
        for (int s = 0; s < 4; s++)
        begin
            if (mask[s])
            begin
                idx = {ch[2], s[1:0], ch[1:0]};
                lv = int'(level_copy[idx]) - vol;
                if (lv < 0)
                    lv = 0;
                if (lv > int'(LEVEL_MAX))
                    lv = int'(LEVEL_MAX);
                synth_writes_q.push_back({ch[2], LEVEL_HI, s[1:0], ch[1:0], lv[7:0], 1'b0});
            end
        end
    endtask

    task automatic predict_writes();
        int n0;
        int mute_vol;
        logic [7:0] d;
        logic [2:0] c;
        fm_write_t tail;
        n0 = synth_writes_q.size();
        mute_vol = mute_on ? int'(MUTE_VOLUME) : int'(OPEN_VOLUME);
        case (action_t'(action))
            ACT_WRITE:
                if (reg_addr >= PSG_TOP)
                begin
                    if (reg_addr == MODE_REG)
                    begin
                        d = reg_data & MODE_MASK;
                        // unchanged mode bits are swallowed
                        if (d[7:6] != mode_copy)
                        begin
                            mode_copy = d[7:6];
                            synth_writes_q.push_back({reg_addr, d, 1'b0});
                        end
                    end
                    else
                    begin
                        if (reg_addr[7:4] == LEVEL_HI)
                            level_copy[{reg_addr[8], reg_addr[3:0]}] = reg_data[6:0];
                        else if (reg_addr[7:2] == ALG_HI)
                            alg_copy[{reg_addr[8], reg_addr[1:0]}] = reg_data[2:0];
                        synth_writes_q.push_back({reg_addr, reg_data, 1'b0});
                    end
                end
            ACT_VOLUME:
                queue_channel(channel, int'(volume));
            ACT_MUTE:
                for (c = 3'd0; c < 3'd3; c++)
                begin
                    queue_channel(c, mute_vol);
                    if (extend_copy)
                        queue_channel(c + 3'd4, mute_vol);
                end
            default:
                ;
        endcase
        if (synth_writes_q.size() > n0)
        begin
            tail = synth_writes_q.pop_back();
            tail.last = 1'b1;
            synth_writes_q.push_back(tail);
        end
    endtask

    task automatic report(input string field, input int expv, input int gotv);
        errors++;
        $display("%0t: %s expected %h got %h", $time, field, expv, gotv);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (level_copy[i])
                level_copy[i] = LEVEL_MAX;
            foreach (alg_copy[i])
                alg_copy[i] = 3'd0;
            mode_copy = 2'd0;
            extend_copy = 1'b1;
            synth_writes_q.delete();
            errors = 0;
        end
        else
        begin
            // results of this edge's input beat cannot leave before the next edge
            if (out_valid && !out_stall)
            begin
                if (synth_writes_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: expected no write got addr %h data %h last %b",
                             $time, out_addr, out_data, last);
                end
                else
                begin
                    want = synth_writes_q.pop_front();
                    if (out_addr !== want.addr)
                        report("out_addr", want.addr, out_addr);
                    if (out_data !== want.data)
                        report("out_data", want.data, out_data);
                    if (last !== want.last)
                        report("last", want.last, last);
                end
            end
            if (has_extend_we)
                extend_copy = has_extend_data;
            if (in_valid && !in_stall)
                predict_writes();
        end
        pending = synth_writes_q.size();
    end

endmodule

>>> test/fm_carrier_volume_shadow_tb.sv
// testbench top: clock, reset, stimulus, output stall pattern and the verdict
module fm_carrier_volume_shadow_tb;
    import fcvs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    action_t           action;
    logic [8:0]        reg_addr;
    logic [7:0]        reg_data;
    logic [2:0]        channel;
    logic signed [7:0] volume;
    logic              mute_on;
    logic              has_extend_we;
    logic              has_extend_data;
    logic              out_valid;
    logic              out_stall;
    logic [8:0]        out_addr;
    logic [7:0]        out_data;
    logic              last;
    int                chk_errors;
    int                chk_pending;
    bit                idle_en;
    bit                long_hold;

    fm_carrier_volume_shadow uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .action          (action),
        .reg_addr        (reg_addr),
        .reg_data        (reg_data),
        .channel         (channel),
        .volume          (volume),
        .mute_on         (mute_on),
        .has_extend_we   (has_extend_we),
        .has_extend_data (has_extend_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_addr        (out_addr),
        .out_data        (out_data),
        .last            (last)
    );

    fm_carrier_volume_shadow_chk chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .action          (action),
        .reg_addr        (reg_addr),
        .reg_data        (reg_data),
        .channel         (channel),
        .volume          (volume),
        .mute_on         (mute_on),
        .has_extend_we   (has_extend_we),
        .has_extend_data (has_extend_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_addr        (out_addr),
        .out_data        (out_data),
        .last            (last),
        .errors          (chk_errors),
        .pending         (chk_pending)
    );

    always #1 clk = ~clk;

    task automatic send_item(input action_t a, input logic [8:0] ad, input logic [7:0] d,
                             input logic [2:0] ch, input logic signed [7:0] v,
                             input logic m);
        int gap;
        gap = idle_en ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        action   <= a;
        reg_addr <= ad;
        reg_data <= d;
        channel  <= ch;
        volume   <= v;
        mute_on  <= m;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
    endtask

    // a random mix of shadow updates and other writes, volume and mute beats, with some noise
    task automatic send_random();
        int pick;
        action_t a;
        logic [8:0] ad;
        logic [7:0] d;
        logic [2:0] ch;
        logic signed [7:0] v;
        pick = $urandom_range(0, 99);
        a  = ACT_WRITE;
        ad = 9'($urandom_range(0, 511));
        d  = 8'($urandom_range(0, 255));
        ch = 3'($urandom_range(0, 7));
        v  = 8'($urandom_range(0, 255));
        if (pick < 28)
            ad[7:4] = LEVEL_HI;
        else if (pick < 42)
            ad[7:2] = ALG_HI;
        else if (pick < 47)
            ad = MODE_REG;
        else if (pick >= 94)
            a = ACT_NONE;
        else if (pick >= 85)
            a = ACT_MUTE;
        else if (pick >= 57)
        begin
            a = ACT_VOLUME;
            if (pick < 62)
                v = pick[0] ? 8'sh7f : 8'sh80;
        end
        send_item(a, ad, d, ch, v, 1'($urandom_range(0, 1)));
    endtask

    task automatic write_extend(input logic val);
        has_extend_we   <= 1'b1;
        has_extend_data <= val;
        @(posedge clk);
        has_extend_we   <= 1'b0;
    endtask

    // wait for every predicted write, then give beats with no result time to finish
    task automatic settle();
        in_valid <= 1'b0;
        do @(negedge clk); while (chk_pending != 0);
        repeat (40) @(posedge clk);
    endtask

    // receiver: random stall before each beat, one long hold-off on request
    initial
    begin
        int n;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            n = idle_en ? $urandom_range(0, 15) : 0;
            if (long_hold)
            begin
                n += 300;
                long_hold = 1'b0;
            end
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid);
        end
    end

    initial
    begin
        idle_en   = 1'b1;
        long_hold = 1'b0;
        rst_n           <= 1'b0;
        in_valid        <= 1'b0;
        action          <= ACT_WRITE;
        reg_addr        <= '0;
        reg_data        <= '0;
        channel         <= '0;
        volume          <= '0;
        mute_on         <= 1'b0;
        has_extend_we   <= 1'b0;
        has_extend_data <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_extend(1'b1);

        // psg range, mode register filtering, bank 1 forwarding
        send_item(ACT_WRITE, 9'h000, 8'hff, 3'd0, 8'sd0, 1'b0);
        send_item(ACT_WRITE, 9'h00f, 8'h00, 3'd0, 8'sd0, 1'b0);
        send_item(ACT_WRITE, 9'h010, 8'hff, 3'd0, 8'sd0, 1'b0);
        send_item(ACT_WRITE, MODE_REG, 8'h3f, 3'd0, 8'sd0, 1'b0);
        send_item(ACT_WRITE, MODE_REG, 8'hc0, 3'd0, 8'sd0, 1'b0);
        send_item(ACT_WRITE, MODE_REG, 8'hff, 3'd0, 8'sd0, 1'b0);
        send_item(ACT_WRITE, MODE_REG, 8'h40, 3'd0, 8'sd0, 1'b0);
        send_item(ACT_WRITE, 9'h127, 8'h80, 3'd0, 8'sd0, 1'b0);
        send_item(ACT_WRITE, 9'h100, 8'h00, 3'd0, 8'sd0, 1'b0);
        // levels and algorithms, with bits above the shadow width
        send_item(ACT_WRITE, 9'h043, 8'hff, 3'd0, 8'sd0, 1'b0);
        send_item(ACT_WRITE, 9'h04f, 8'h80, 3'd0, 8'sd0, 1'b0);
        send_item(ACT_WRITE, 9'h14c, 8'h05, 3'd0, 8'sd0, 1'b0);
        send_item(ACT_WRITE, 9'h0b3, 8'hff, 3'd0, 8'sd0, 1'b0);
        send_item(ACT_WRITE, 9'h1b0, 8'h04, 3'd0, 8'sd0, 1'b0);
        // saturation at both ends on channels 0, 3, 4 and 7, then mutes, a no-op and more writes
        send_item(ACT_VOLUME, 9'h000, 8'h00, 3'd3, 8'sh80, 1'b0);
        send_item(ACT_VOLUME, 9'h000, 8'h00, 3'd3, 8'sh7f, 1'b0);
        send_item(ACT_VOLUME, 9'h000, 8'h00, 3'd4, 8'sd0, 1'b0);
        send_item(ACT_VOLUME, 9'h000, 8'h00, 3'd7, 8'sd1, 1'b0);
        send_item(ACT_VOLUME, 9'h000, 8'h00, 3'd0, -8'sd1, 1'b0);
        send_item(ACT_MUTE, 9'h000, 8'h00, 3'd0, 8'sd0, 1'b1);
        send_item(ACT_MUTE, 9'h000, 8'h00, 3'd0, 8'sd0, 1'b0);
        send_item(ACT_NONE, 9'h1ff, 8'hff, 3'd7, 8'sh7f, 1'b1);
        send_item(ACT_WRITE, 9'h1ff, 8'hff, 3'd7, 8'sh7f, 1'b1);
        send_item(ACT_WRITE, 9'h1b7, 8'hfe, 3'd0, 8'sd0, 1'b0);
        send_item(ACT_VOLUME, 9'h000, 8'h00, 3'd7, 8'sh80, 1'b0);
        settle();

        write_extend(1'b0);
        repeat (120) send_random();
        settle();

        // long receiver hold-off while beats keep coming, then a full drain mid-phase
        write_extend(1'b1);
        repeat (40) send_random();
        long_hold = 1'b1;
        repeat (40) send_random();
        settle();
        repeat (40) send_random();
        settle();

        // back to back on both sides
        idle_en = 1'b0;
        write_extend(1'b0);
        repeat (100) send_random();
        settle();

        if (chk_errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #1_500_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/fcvs_pkg.sv
hw/rtl/fcvs_level_unit.sv
hw/rtl/fcvs_sequencer.sv
hw/rtl/fm_carrier_volume_shadow.sv
test/fm_carrier_volume_shadow_chk.sv
test/fm_carrier_volume_shadow_tb.sv
